/* rtl/core/rgb_box_blur_3x3_core_macros.svh */
// assertion helpers used by the core rtl file
`ifndef RGB_BOX_BLUR_3X3_CORE_MACROS_SVH
`define RGB_BOX_BLUR_3X3_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define RBB3_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbb3 assertion failed");

// next-cycle implication
`define RBB3_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbb3 assertion failed");

`else

`define RBB3_ASSERT_IMP(label, clk, rst, ante, cons)
`define RBB3_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/rbb3_pkg.sv */
package rbb3_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);

   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam int CH_W         = 8;
   localparam int PIX_W        = 3 * CH_W;
   localparam int SUM_W        = 12;
   localparam int RECIP_W      = 17;
   localparam int DIV_SHIFT    = 16;
   localparam int PROD_W       = SUM_W + RECIP_W;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;
   // rows of one column: [0] row above, [1] center row, [2] row below
   typedef pix_type [2:0] col_type;
   // columns of the window: [0] right, [1] center, [2] left
   typedef col_type [2:0] win_type;

   typedef struct packed {
      logic       emit;
      logic       last;
      logic [2:0] col_en;
      logic [2:0] row_en;
   } emit_ctrl_type;

   // ceil(2^16 / cnt), exact for every sum of up to nine 8-bit values
   function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] cnt);
      logic [RECIP_W-1:0] r;
      case (cnt)
         4'd1:    r = RECIP_W'(65536);
         4'd2:    r = RECIP_W'(32768);
         4'd3:    r = RECIP_W'(21846);
         4'd4:    r = RECIP_W'(16384);
         4'd6:    r = RECIP_W'(10923);
         4'd9:    r = RECIP_W'(7282);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/rbb3_avg.sv */
module rbb3_avg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  rbb3_pkg::emit_ctrl_type ctrl,
   input  rbb3_pkg::win_type      window,
   output logic                   res_valid,
   output logic                   res_last,
   output rbb3_pkg::pix_type      res_pix
);

   logic [2:0][rbb3_pkg::SUM_W-1:0]   sum_in;
   logic [2:0][rbb3_pkg::SUM_W-1:0]   sum_ff;
   logic [rbb3_pkg::RECIP_W-1:0]      recip_in;
   logic [rbb3_pkg::RECIP_W-1:0]      recip_ff;
   logic                              valid_ff;
   logic                              last_ff;
   logic [2:0][rbb3_pkg::PROD_W-1:0]  prod;

   always_comb begin
      logic [1:0] n_h;
      logic [1:0] n_v;
      logic [3:0] cnt;
      sum_in = '0;
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            for (int ch = 0; ch < 3; ch++) begin
               if (ctrl.col_en[c] && ctrl.row_en[r]) begin
                  sum_in[ch] = sum_in[ch]
                     + rbb3_pkg::SUM_W'(window[c][r][rbb3_pkg::CH_W*ch +: rbb3_pkg::CH_W]);
               end
            end
         end
      end
      n_h      = 2'($countones(ctrl.col_en));
      n_v      = 2'($countones(ctrl.row_en));
      cnt      = {2'b00, n_h} * {2'b00, n_v};
      recip_in = rbb3_pkg::recip_of(cnt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctrl.emit;
      end
      if (advance) begin
         sum_ff   <= sum_in;
         recip_ff <= recip_in;
         last_ff  <= ctrl.last;
      end
   end

   // divide by the neighbor count as a multiply by its reciprocal
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = rbb3_pkg::PROD_W'(sum_ff[ch]) * rbb3_pkg::PROD_W'(recip_ff);
         res_pix[rbb3_pkg::CH_W*ch +: rbb3_pkg::CH_W] =
            prod[ch][rbb3_pkg::DIV_SHIFT +: rbb3_pkg::CH_W];
      end
   end

   assign res_valid = valid_ff;
   assign res_last  = last_ff;

endmodule

/* rtl/core/rgb_box_blur_3x3_core.sv */
// channel  dir  handshake                    payload
// req      in   req_tvalid / req_tready      tuser: cmd; tdata: red, green, blue
// rsp      out  rsp_tvalid / rsp_tready      tdata: red, green, blue; tlast: frame_last
// csr      in   psel/penable/pwrite, pready  frame_width @0x0, frame_height @0x4
//
// one item per cycle unless a result is stalled; a result passes the read, window, average and output registers
// an extra column step is spent after the last pixel of a single-row frame (req_tready low)
// two line memories are read one column per item, written back from the column read stage
// with a bypass when the same column is touched by back-to-back items
// reset is synchronous; no memory clearing pass is needed
// a stalled result holds the whole pipeline and req_tready
`include "rgb_box_blur_3x3_core_macros.svh"

module rgb_box_blur_3x3_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rbb3_pkg::PIX_W-1:0]          req_tdata,   // red, green, blue
   input  logic                                req_tuser,   // cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rbb3_pkg::PIX_W-1:0]          rsp_tdata,   // red, green, blue
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rbb3_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rbb3_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rbb3_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   // config
   logic [rbb3_pkg::WIDTH_REG_W-1:0]  width_ff;
   logic [rbb3_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic [rbb3_pkg::WIDTH_REG_W-1:0]  eff_w;
   logic [rbb3_pkg::HEIGHT_REG_W-1:0] eff_h;
   logic [rbb3_pkg::COL_W-1:0]        w_last;
   logic [rbb3_pkg::ROW_W-1:0]        h_last;
   logic                              csr_wr;

   // frame position
   logic [rbb3_pkg::COL_W-1:0] rcv_col_ff;
   logic [rbb3_pkg::ROW_W-1:0] rcv_row_ff;
   logic                       rcv_done_ff;
   logic                       pad_pend_ff;
   logic [rbb3_pkg::COL_W-1:0] emit_col_ff;
   logic [rbb3_pkg::ROW_W-1:0] emit_row_ff;

   // item decode
   logic advance;
   logic acc;
   logic is_pixel;
   logic drain_emit;
   logic pad_go;
   logic primed;
   logic do_shift;
   logic do_emit;
   logic s0_last;
   logic rcv_wrap;
   rbb3_pkg::emit_ctrl_type s0_ctrl;

   // column read / write-back stage
   logic                       s1_shift_ff;
   logic [rbb3_pkg::COL_W-1:0] s1_col_ff;
   rbb3_pkg::pix_type          s1_pix_ff;
   rbb3_pkg::emit_ctrl_type    s1_ctrl_ff;
   rbb3_pkg::pix_type          rd_up_ff;
   rbb3_pkg::pix_type          rd_mid_ff;
   logic                       byp_hit_ff;
   rbb3_pkg::pix_type          byp_up_ff;
   rbb3_pkg::pix_type          byp_mid_ff;
   rbb3_pkg::pix_type          eff_up;
   rbb3_pkg::pix_type          eff_mid;
   logic                       hit;

   rbb3_pkg::pix_type upper_mem  [rbb3_pkg::MAX_WIDTH];
   rbb3_pkg::pix_type middle_mem [rbb3_pkg::MAX_WIDTH];

   // window stage
   rbb3_pkg::win_type       win_ff;
   rbb3_pkg::emit_ctrl_type s2_ctrl_ff;

   // output
   logic              avg_valid;
   logic              avg_last;
   rbb3_pkg::pix_type avg_pix;
   logic              rsp_valid_ff;
   rbb3_pkg::pix_type rsp_data_ff;
   logic              rsp_last_ff;

   // ---------------------------------------------------------------- config
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      if (csr_paddr[2] == rbb3_pkg::REG_FRAME_WIDTH) begin
         csr_prdata = rbb3_pkg::CSR_DATA_W'(width_ff);
      end else begin
         csr_prdata = rbb3_pkg::CSR_DATA_W'(height_ff);
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_w = rbb3_pkg::WIDTH_REG_W'(1);
      end else if (width_ff > rbb3_pkg::WIDTH_REG_W'(rbb3_pkg::MAX_WIDTH)) begin
         eff_w = rbb3_pkg::WIDTH_REG_W'(rbb3_pkg::MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = rbb3_pkg::HEIGHT_REG_W'(1);
      end else if (height_ff > rbb3_pkg::HEIGHT_REG_W'(rbb3_pkg::MAX_HEIGHT)) begin
         eff_h = rbb3_pkg::HEIGHT_REG_W'(rbb3_pkg::MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign w_last = rbb3_pkg::COL_W'(eff_w - rbb3_pkg::WIDTH_REG_W'(1));
   assign h_last = rbb3_pkg::ROW_W'(eff_h - rbb3_pkg::HEIGHT_REG_W'(1));

   // ---------------------------------------------------------------- decode
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance && !pad_pend_ff;
   assign acc        = req_tvalid && req_tready;
   assign is_pixel   = acc && (req_tuser == rbb3_pkg::CMD_PIXEL) && !rcv_done_ff;
   // after the last pixel every beat, pixel or drain, pushes out one result
   assign drain_emit = acc && rcv_done_ff;
   // single-row frame: one internal column step to line the window up
   assign pad_go     = advance && pad_pend_ff;

   assign primed = (rcv_row_ff > rbb3_pkg::ROW_W'(1))
                   || ((rcv_row_ff == rbb3_pkg::ROW_W'(1)) && (rcv_col_ff != '0));

   assign do_shift = is_pixel || drain_emit || pad_go;
   assign do_emit  = (is_pixel && primed) || drain_emit;
   assign s0_last  = (emit_row_ff == h_last) && (emit_col_ff == w_last);
   assign rcv_wrap = (rcv_col_ff == w_last);

   always_comb begin
      s0_ctrl.emit   = do_emit;
      s0_ctrl.last   = s0_last;
      s0_ctrl.col_en = {emit_col_ff != '0, 1'b1, emit_col_ff != w_last};
      s0_ctrl.row_en = {emit_row_ff != h_last, 1'b1, emit_row_ff != '0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= rbb3_pkg::WIDTH_REG_W'(rbb3_pkg::WIDTH_RESET);
         height_ff   <= rbb3_pkg::HEIGHT_REG_W'(rbb3_pkg::HEIGHT_RESET);
         rcv_col_ff  <= '0;
         rcv_row_ff  <= '0;
         rcv_done_ff <= 1'b0;
         pad_pend_ff <= 1'b0;
         emit_col_ff <= '0;
         emit_row_ff <= '0;
      end else begin
         if (do_shift) begin
            rcv_col_ff <= rcv_wrap ? '0 : rcv_col_ff + rbb3_pkg::COL_W'(1);
         end
         if (is_pixel && rcv_wrap) begin
            rcv_row_ff <= rcv_row_ff + rbb3_pkg::ROW_W'(1);
         end
         if (is_pixel && rcv_wrap && (rcv_row_ff == h_last)) begin
            rcv_done_ff <= 1'b1;
            pad_pend_ff <= (h_last == '0);
         end
         if (pad_go) begin
            pad_pend_ff <= 1'b0;
         end
         if (do_emit) begin
            if (s0_last) begin
               rcv_col_ff  <= '0;
               rcv_row_ff  <= '0;
               rcv_done_ff <= 1'b0;
               emit_col_ff <= '0;
               emit_row_ff <= '0;
            end else if (emit_col_ff == w_last) begin
               emit_col_ff <= '0;
               emit_row_ff <= emit_row_ff + rbb3_pkg::ROW_W'(1);
            end else begin
               emit_col_ff <= emit_col_ff + rbb3_pkg::COL_W'(1);
            end
         end
         if (csr_wr) begin
            if (csr_paddr[2] == rbb3_pkg::REG_FRAME_WIDTH) begin
               width_ff <= csr_pwdata[rbb3_pkg::WIDTH_REG_W-1:0];
            end else begin
               height_ff <= csr_pwdata[rbb3_pkg::HEIGHT_REG_W-1:0];
            end
            rcv_col_ff  <= '0;
            rcv_row_ff  <= '0;
            rcv_done_ff <= 1'b0;
            pad_pend_ff <= 1'b0;
            emit_col_ff <= '0;
            emit_row_ff <= '0;
         end
      end
   end

   // ---------------------------------------------------------------- line memories
   assign hit     = s1_shift_ff && (s1_col_ff == rcv_col_ff);
   assign eff_up  = byp_hit_ff ? byp_up_ff : rd_up_ff;
   assign eff_mid = byp_hit_ff ? byp_mid_ff : rd_mid_ff;

   always_ff @(posedge clock) begin
      if (advance && do_shift) begin
         rd_up_ff  <= upper_mem[rcv_col_ff];
         rd_mid_ff <= middle_mem[rcv_col_ff];
      end
      // rows move up one line as the column is written back
      if (advance && s1_shift_ff) begin
         upper_mem[s1_col_ff]  <= eff_mid;
         middle_mem[s1_col_ff] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_shift_ff     <= 1'b0;
         s1_ctrl_ff.emit <= 1'b0;
         byp_hit_ff      <= 1'b0;
         s2_ctrl_ff.emit <= 1'b0;
      end else if (advance) begin
         s1_shift_ff     <= do_shift;
         s1_ctrl_ff.emit <= s0_ctrl.emit;
         if (do_shift) begin
            byp_hit_ff <= hit;
         end
         s2_ctrl_ff.emit <= s1_ctrl_ff.emit;
      end
      if (advance) begin
         s1_col_ff         <= rcv_col_ff;
         s1_pix_ff         <= req_tdata;
         s1_ctrl_ff.last   <= s0_ctrl.last;
         s1_ctrl_ff.col_en <= s0_ctrl.col_en;
         s1_ctrl_ff.row_en <= s0_ctrl.row_en;
         if (do_shift) begin
            byp_up_ff  <= eff_mid;
            byp_mid_ff <= s1_pix_ff;
         end
         s2_ctrl_ff.last   <= s1_ctrl_ff.last;
         s2_ctrl_ff.col_en <= s1_ctrl_ff.col_en;
         s2_ctrl_ff.row_en <= s1_ctrl_ff.row_en;
         if (s1_shift_ff) begin
            win_ff <= {win_ff[1], win_ff[0], {s1_pix_ff, eff_mid, eff_up}};
         end
      end
   end

   // ---------------------------------------------------------------- average
   rbb3_avg u_avg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctrl      (s2_ctrl_ff),
      .window    (win_ff),
      .res_valid (avg_valid),
      .res_last  (avg_last),
      .res_pix   (avg_pix)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= avg_valid;
      end
      if (advance) begin
         rsp_data_ff <= avg_pix;
         rsp_last_ff <= avg_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   `RBB3_ASSERT_NEXT(a_bypass_taken, clock, reset, advance && do_shift && hit, byp_hit_ff)
   `RBB3_ASSERT_NEXT(a_last_restarts, clock, reset, do_emit && s0_last, !rcv_done_ff && (emit_col_ff == '0) && (emit_row_ff == '0))
   `RBB3_ASSERT_IMP(a_pad_single_row, clock, reset, pad_pend_ff, rcv_done_ff && (h_last == '0))
   `RBB3_ASSERT_IMP(a_emit_has_column, clock, reset, s1_ctrl_ff.emit, s1_shift_ff)

endmodule
